// ===== rtl/core/shw_pkg.sv =====
package shw_pkg;

    // Fixed field widths of the item ports.
    localparam int PIVOT_W = 16;
    localparam int POS_W   = 16;
    localparam int SCALE_W = 8;
    localparam int TURN_W  = 2;
    localparam int FLIP_W  = 2;
    localparam int OUT_W   = 22;

    // Bit positions inside flip_mode.
    localparam int FLIP_H_BIT = 0;
    localparam int FLIP_V_BIT = 1;

    // Quarter-turn codes.
    localparam logic [TURN_W-1:0] TURN_NONE    = 2'd0;
    localparam logic [TURN_W-1:0] TURN_QUARTER = 2'd1;
    localparam logic [TURN_W-1:0] TURN_HALF    = 2'd2;
    localparam logic [TURN_W-1:0] TURN_THREE   = 2'd3;

    // Saturation bounds of a world edge.
    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Width of a box edge relative to the anchor, in fixed point. It has room
    // for the edge, the anchor (pivot plus one half) and a negation.
    function automatic int local_w(int edge_bits, int frac_bits);
        int ew;
        ew = edge_bits + frac_bits;
        if (ew < PIVOT_W + 1) begin
            ew = PIVOT_W + 1;
        end
        return ew + 2;
    endfunction

    // Width of the scaled and offset sum; wide enough that the rounded value
    // can always be compared against the output bounds.
    function automatic int sum_w(int edge_bits, int frac_bits);
        int a;
        int b;
        a = local_w(edge_bits, frac_bits) + SCALE_W;
        b = POS_W + frac_bits;
        if (b > a) begin
            a = b;
        end
        a = a + 3;
        if (a < OUT_W + frac_bits + 1) begin
            a = OUT_W + frac_bits + 1;
        end
        return a;
    endfunction

endpackage

// ===== rtl/core/shw_local.sv =====
module shw_local #(
    parameter int FRAC_BITS = 4,
    parameter int EDGE_BITS = 12,
    parameter int LW = shw_pkg::local_w(EDGE_BITS, FRAC_BITS),
    parameter int SW = shw_pkg::sum_w(EDGE_BITS, FRAC_BITS)
) (
    input  logic [EDGE_BITS-1:0]               src_left,
    input  logic [EDGE_BITS-1:0]               src_top,
    input  logic [EDGE_BITS-1:0]               src_right,
    input  logic [EDGE_BITS-1:0]               src_bottom,
    input  logic [shw_pkg::PIVOT_W-1:0]        pivot_x,
    input  logic [shw_pkg::PIVOT_W-1:0]        pivot_y,
    input  logic signed [shw_pkg::POS_W-1:0]   pos_x,
    input  logic signed [shw_pkg::POS_W-1:0]   pos_y,
    input  logic [shw_pkg::TURN_W-1:0]         quarter_turns,
    input  logic [shw_pkg::SCALE_W-1:0]        scale_x,
    input  logic [shw_pkg::SCALE_W-1:0]        scale_y,
    input  logic [shw_pkg::FLIP_W-1:0]         flip_mode,
    output logic signed [LW-1:0]               loc_left,
    output logic signed [LW-1:0]               loc_top,
    output logic signed [LW-1:0]               loc_right,
    output logic signed [LW-1:0]               loc_bottom,
    output logic signed [SW-1:0]               origin_x,
    output logic signed [SW-1:0]               origin_y,
    output logic [shw_pkg::SCALE_W-1:0]        eff_scale_x,
    output logic [shw_pkg::SCALE_W-1:0]        eff_scale_y
);

    logic signed [LW-1:0] anchor_x;
    logic signed [LW-1:0] anchor_y;
    logic signed [LW-1:0] l0, t0, r0, b0;
    logic signed [LW-1:0] l1, t1, r1, b1;
    logic signed [LW-1:0] l2, t2, r2, b2;

    // Anchor sits half a pixel past the pivot.
    assign anchor_x = LW'(pivot_x) + (LW'(1) << (FRAC_BITS - 1));
    assign anchor_y = LW'(pivot_y) + (LW'(1) << (FRAC_BITS - 1));

    assign l0 = (LW'(src_left) << FRAC_BITS) - anchor_x;
    assign r0 = (LW'(src_right) << FRAC_BITS) - anchor_x;
    assign t0 = (LW'(src_top) << FRAC_BITS) - anchor_y;
    assign b0 = (LW'(src_bottom) << FRAC_BITS) - anchor_y;

    // Mirroring swaps the pair and negates it.
    assign l1 = flip_mode[shw_pkg::FLIP_H_BIT] ? -r0 : l0;
    assign r1 = flip_mode[shw_pkg::FLIP_H_BIT] ? -l0 : r0;
    assign t1 = flip_mode[shw_pkg::FLIP_V_BIT] ? -b0 : t0;
    assign b1 = flip_mode[shw_pkg::FLIP_V_BIT] ? -t0 : b0;

    always_comb begin
        case (quarter_turns)
            shw_pkg::TURN_QUARTER: begin
                l2 = b1;  r2 = t1;  b2 = -r1; t2 = -l1;
            end
            shw_pkg::TURN_HALF: begin
                l2 = -r1; r2 = -l1; b2 = -t1; t2 = -b1;
            end
            shw_pkg::TURN_THREE: begin
                l2 = -t1; r2 = -b1; b2 = l1;  t2 = r1;
            end
            default: begin
                l2 = l1;  r2 = r1;  b2 = b1;  t2 = t1;
            end
        endcase
    end

    // Rotated boxes are put back in order; an unrotated box is left as given.
    always_comb begin
        loc_left   = l2;
        loc_right  = r2;
        loc_top    = t2;
        loc_bottom = b2;
        if (quarter_turns != shw_pkg::TURN_NONE) begin
            if (l2 > r2) begin
                loc_left  = r2;
                loc_right = l2;
            end
            if (b2 > t2) begin
                loc_bottom = t2;
                loc_top    = b2;
            end
        end
    end

    assign eff_scale_x = quarter_turns[0] ? scale_y : scale_x;
    assign eff_scale_y = quarter_turns[0] ? scale_x : scale_y;

    assign origin_x = (SW'(pos_x) <<< FRAC_BITS) - (SW'(eff_scale_x) << (FRAC_BITS - 1));
    assign origin_y = (SW'(pos_y) <<< FRAC_BITS) + (SW'(eff_scale_y) << (FRAC_BITS - 1));

endmodule

// ===== rtl/core/shw_edge.sv =====
module shw_edge #(
    parameter int FRAC_BITS = 4,
    parameter int EDGE_BITS = 12,
    parameter int LW = shw_pkg::local_w(EDGE_BITS, FRAC_BITS),
    parameter int SW = shw_pkg::sum_w(EDGE_BITS, FRAC_BITS)
) (
    input  logic signed [LW-1:0]               loc,
    input  logic [shw_pkg::SCALE_W-1:0]        scale,
    input  logic signed [SW-1:0]               origin,
    output logic signed [shw_pkg::OUT_W-1:0]   world
);

    localparam int PW = LW + shw_pkg::SCALE_W + 1;
    localparam int RW = SW - FRAC_BITS;
    localparam logic signed [RW-1:0] MAX_R = RW'(shw_pkg::OUT_MAX);
    localparam logic signed [RW-1:0] MIN_R = RW'(shw_pkg::OUT_MIN);

    logic signed [PW-1:0] prod;
    logic signed [SW-1:0] acc;
    logic signed [RW-1:0] rnd;

    assign prod = loc * $signed({1'b0, scale});
    assign acc  = origin + SW'(prod) + (SW'(1) << (FRAC_BITS - 1));
    // Dropping the fraction bits of a two's complement value is a floor.
    assign rnd  = acc[SW-1:FRAC_BITS];

    always_comb begin
        if (rnd > MAX_R) begin
            world = shw_pkg::OUT_MAX;
        end else if (rnd < MIN_R) begin
            world = shw_pkg::OUT_MIN;
        end else begin
            world = rnd[shw_pkg::OUT_W-1:0];
        end
    end

endmodule

// ===== rtl/core/sprite_hitbox_world_bounds.sv =====
// Channel | Direction | Handshake          | Payload
// s_      | in        | s_valid / s_ready  | box edges, pivot, position, turns, scales, flips
// m_      | out       | m_valid / m_ready  | world_left, world_top, world_right, world_bottom
//
// One item per cycle is sustained while m_ready is high. The edge that accepts an item
// loads the input register; the result register loads from it once it is free, and the
// result shows on m_ from the result register.
// aresetn is synchronous and active low; it clears both valid flags only.
// A stall on m_ holds the result register; s_ready drops only when both registers
// are full and m_ready is low.
module sprite_hitbox_world_bounds #(
    parameter int FRAC_BITS = 4,
    parameter int EDGE_BITS = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [EDGE_BITS-1:0]                s_src_left,
    input  logic [EDGE_BITS-1:0]                s_src_top,
    input  logic [EDGE_BITS-1:0]                s_src_right,
    input  logic [EDGE_BITS-1:0]                s_src_bottom,
    input  logic [shw_pkg::PIVOT_W-1:0]         s_pivot_x,
    input  logic [shw_pkg::PIVOT_W-1:0]         s_pivot_y,
    input  logic signed [shw_pkg::POS_W-1:0]    s_pos_x,
    input  logic signed [shw_pkg::POS_W-1:0]    s_pos_y,
    input  logic [shw_pkg::TURN_W-1:0]          s_quarter_turns,
    input  logic [shw_pkg::SCALE_W-1:0]         s_scale_x,
    input  logic [shw_pkg::SCALE_W-1:0]         s_scale_y,
    input  logic [shw_pkg::FLIP_W-1:0]          s_flip_mode,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [shw_pkg::OUT_W-1:0]    m_world_left,
    output logic signed [shw_pkg::OUT_W-1:0]    m_world_top,
    output logic signed [shw_pkg::OUT_W-1:0]    m_world_right,
    output logic signed [shw_pkg::OUT_W-1:0]    m_world_bottom
);

    localparam int LW = shw_pkg::local_w(EDGE_BITS, FRAC_BITS);
    localparam int SW = shw_pkg::sum_w(EDGE_BITS, FRAC_BITS);

    // Input register: one item, captured as it arrives.
    logic                               in_valid_reg;
    logic [EDGE_BITS-1:0]               left_reg, top_reg, right_reg, bottom_reg;
    logic [shw_pkg::PIVOT_W-1:0]        pivot_x_reg, pivot_y_reg;
    logic signed [shw_pkg::POS_W-1:0]   pos_x_reg, pos_y_reg;
    logic [shw_pkg::TURN_W-1:0]         turns_reg;
    logic [shw_pkg::SCALE_W-1:0]        scale_x_reg, scale_y_reg;
    logic [shw_pkg::FLIP_W-1:0]         flip_reg;

    // Result register.
    logic                               out_valid_reg;
    logic signed [shw_pkg::OUT_W-1:0]   wl_reg, wt_reg, wr_reg, wb_reg;

    logic signed [LW-1:0]               loc_left, loc_top, loc_right, loc_bottom;
    logic signed [SW-1:0]               origin_x, origin_y;
    logic [shw_pkg::SCALE_W-1:0]        eff_scale_x, eff_scale_y;
    logic signed [shw_pkg::OUT_W-1:0]   wl_next, wt_next, wr_next, wb_next;

    logic out_free;
    logic s_fire;

    // The result register can load when it is empty or being drained.
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_free;
    assign s_fire   = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            left_reg    <= s_src_left;
            top_reg     <= s_src_top;
            right_reg   <= s_src_right;
            bottom_reg  <= s_src_bottom;
            pivot_x_reg <= s_pivot_x;
            pivot_y_reg <= s_pivot_y;
            pos_x_reg   <= s_pos_x;
            pos_y_reg   <= s_pos_y;
            turns_reg   <= s_quarter_turns;
            scale_x_reg <= s_scale_x;
            scale_y_reg <= s_scale_y;
            flip_reg    <= s_flip_mode;
        end
    end

    // Anchor, mirror, rotate and reorder the box, and form both origins.
    shw_local #(
        .FRAC_BITS (FRAC_BITS),
        .EDGE_BITS (EDGE_BITS),
        .LW        (LW),
        .SW        (SW)
    ) u_local (
        .src_left      (left_reg),
        .src_top       (top_reg),
        .src_right     (right_reg),
        .src_bottom    (bottom_reg),
        .pivot_x       (pivot_x_reg),
        .pivot_y       (pivot_y_reg),
        .pos_x         (pos_x_reg),
        .pos_y         (pos_y_reg),
        .quarter_turns (turns_reg),
        .scale_x       (scale_x_reg),
        .scale_y       (scale_y_reg),
        .flip_mode     (flip_reg),
        .loc_left      (loc_left),
        .loc_top       (loc_top),
        .loc_right     (loc_right),
        .loc_bottom    (loc_bottom),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .eff_scale_x   (eff_scale_x),
        .eff_scale_y   (eff_scale_y)
    );

    // Each edge gets its own small multiplier, offset, rounding and clamp.
    shw_edge #(.FRAC_BITS(FRAC_BITS), .EDGE_BITS(EDGE_BITS), .LW(LW), .SW(SW)) u_edge_left (
        .loc (loc_left), .scale (eff_scale_x), .origin (origin_x), .world (wl_next)
    );

    shw_edge #(.FRAC_BITS(FRAC_BITS), .EDGE_BITS(EDGE_BITS), .LW(LW), .SW(SW)) u_edge_top (
        .loc (loc_top), .scale (eff_scale_y), .origin (origin_y), .world (wt_next)
    );

    shw_edge #(.FRAC_BITS(FRAC_BITS), .EDGE_BITS(EDGE_BITS), .LW(LW), .SW(SW)) u_edge_right (
        .loc (loc_right), .scale (eff_scale_x), .origin (origin_x), .world (wr_next)
    );

    shw_edge #(.FRAC_BITS(FRAC_BITS), .EDGE_BITS(EDGE_BITS), .LW(LW), .SW(SW)) u_edge_bottom (
        .loc (loc_bottom), .scale (eff_scale_y), .origin (origin_y), .world (wb_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && in_valid_reg) begin
            wl_reg <= wl_next;
            wt_reg <= wt_next;
            wr_reg <= wr_next;
            wb_reg <= wb_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_world_left   = wl_reg;
    assign m_world_top    = wt_reg;
    assign m_world_right  = wr_reg;
    assign m_world_bottom = wb_reg;

`ifndef SYNTHESIS
    // An accepted item always lands in the input register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> in_valid_reg)
        else $error("accepted item not captured");

    // An item in the input register moves on whenever the result side is free.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_free) |=> m_valid)
        else $error("item lost between input and result registers");

    // With a stalled result, a held input item stays put.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !out_free) |=> (in_valid_reg && $stable(left_reg)
            && $stable(turns_reg)))
        else $error("input register changed under a stall");

    // Reset empties both registers.
    assert property (@(posedge aclk)
        !aresetn |=> (!in_valid_reg && !m_valid))
        else $error("valid flags not cleared by reset");
`endif

endmodule

// ===== bench/tb_sprite_hitbox_world_bounds.sv =====
module tb_sprite_hitbox_world_bounds;
    timeunit 1ns;
    timeprecision 1ps;

    // Widths the block is built with here; the predictor uses the same ones.
    localparam int FRAC_BITS = 4;
    localparam int EDGE_BITS = 12;

    // One half pixel in fixed point.
    localparam longint HALF = longint'(1) << (FRAC_BITS - 1);

    // A result passes only the input and result registers before it shows, so a
    // handful of quiet cycles at the end is plenty to catch a stray result.
    localparam int TAIL_CYCLES    = 10;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int HOLD_ITEMS     = 40;
    localparam int PHASE_ITEMS    = 225;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int MAX_REPORTS    = 10;

    // One hitbox item as it goes into the block.
    typedef struct {
        logic [EDGE_BITS-1:0]               src_left;
        logic [EDGE_BITS-1:0]               src_top;
        logic [EDGE_BITS-1:0]               src_right;
        logic [EDGE_BITS-1:0]               src_bottom;
        logic [shw_pkg::PIVOT_W-1:0]        pivot_x;
        logic [shw_pkg::PIVOT_W-1:0]        pivot_y;
        logic signed [shw_pkg::POS_W-1:0]   pos_x;
        logic signed [shw_pkg::POS_W-1:0]   pos_y;
        logic [shw_pkg::TURN_W-1:0]         quarter_turns;
        logic [shw_pkg::SCALE_W-1:0]        scale_x;
        logic [shw_pkg::SCALE_W-1:0]        scale_y;
        logic [shw_pkg::FLIP_W-1:0]         flip_mode;
    } box_item_t;

    // The world-space box that comes back for one item.
    typedef struct {
        logic signed [shw_pkg::OUT_W-1:0] left;
        logic signed [shw_pkg::OUT_W-1:0] top;
        logic signed [shw_pkg::OUT_W-1:0] right;
        logic signed [shw_pkg::OUT_W-1:0] bottom;
    } world_box_t;

    // Every input starts at a known value; the driver and the receiver take
    // over at the first clock edge.
    logic                               aclk = 1'b0;
    logic                               aresetn = 1'b0;
    logic                               s_valid = 1'b0;
    logic                               s_ready;
    logic [EDGE_BITS-1:0]               s_src_left = '0;
    logic [EDGE_BITS-1:0]               s_src_top = '0;
    logic [EDGE_BITS-1:0]               s_src_right = '0;
    logic [EDGE_BITS-1:0]               s_src_bottom = '0;
    logic [shw_pkg::PIVOT_W-1:0]        s_pivot_x = '0;
    logic [shw_pkg::PIVOT_W-1:0]        s_pivot_y = '0;
    logic signed [shw_pkg::POS_W-1:0]   s_pos_x = '0;
    logic signed [shw_pkg::POS_W-1:0]   s_pos_y = '0;
    logic [shw_pkg::TURN_W-1:0]         s_quarter_turns = shw_pkg::TURN_NONE;
    logic [shw_pkg::SCALE_W-1:0]        s_scale_x = '0;
    logic [shw_pkg::SCALE_W-1:0]        s_scale_y = '0;
    logic [shw_pkg::FLIP_W-1:0]         s_flip_mode = '0;
    logic                               m_valid;
    logic                               m_ready = 1'b0;
    logic signed [shw_pkg::OUT_W-1:0]   m_world_left;
    logic signed [shw_pkg::OUT_W-1:0]   m_world_top;
    logic signed [shw_pkg::OUT_W-1:0]   m_world_right;
    logic signed [shw_pkg::OUT_W-1:0]   m_world_bottom;

    // Boxes waiting to be offered, and world boxes predicted for items the
    // block has accepted but not yet answered.
    box_item_t  pending_boxes[$];
    world_box_t expected_boxes[$];
    box_item_t  cur_box;
    world_box_t got_box;
    world_box_t want_box;

    int queued_count   = 0;
    int accepted_count = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;

    // Idle rates in percent for the sender and the receiver, set per phase.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Long receiver hold-off: the stimulus raises the request, the receiver
    // counts the cycles itself and flags when it is done.
    logic rx_hold_req = 1'b0;
    logic rx_hold_done = 1'b0;
    int   rx_hold_count = 0;

    sprite_hitbox_world_bounds #(
        .FRAC_BITS (FRAC_BITS),
        .EDGE_BITS (EDGE_BITS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_src_left      (s_src_left),
        .s_src_top       (s_src_top),
        .s_src_right     (s_src_right),
        .s_src_bottom    (s_src_bottom),
        .s_pivot_x       (s_pivot_x),
        .s_pivot_y       (s_pivot_y),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_quarter_turns (s_quarter_turns),
        .s_scale_x       (s_scale_x),
        .s_scale_y       (s_scale_y),
        .s_flip_mode     (s_flip_mode),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_world_left    (m_world_left),
        .m_world_top     (m_world_top),
        .m_world_right   (m_world_right),
        .m_world_bottom  (m_world_bottom)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Adds one half, floors away the fraction and clamps to the 22-bit
    // output range, which is how each world edge is rounded.
    function automatic logic signed [shw_pkg::OUT_W-1:0] round_world_edge(longint v);
        longint f;
        f = (v + HALF) >>> FRAC_BITS;
        if (f > longint'(shw_pkg::OUT_MAX)) begin
            return shw_pkg::OUT_MAX;
        end
        if (f < longint'(shw_pkg::OUT_MIN)) begin
            return shw_pkg::OUT_MIN;
        end
        return f[shw_pkg::OUT_W-1:0];
    endfunction

    // Computes the world box for one hitbox item. Everything is held in
    // sixteenths of a pixel, so the half-pixel anchor and the half-scale
    // origin shift stay exact.
    function automatic world_box_t predict_world_box(box_item_t b);
        longint one;
        longint ax, ay;
        longint lft, top, rgt, bot;
        longint l0, t0, r0, b0;
        longint sx, sy, ox, oy, tmp;
        world_box_t w;
        one = longint'(1) << FRAC_BITS;
        ax = longint'(b.pivot_x) + HALF;
        ay = longint'(b.pivot_y) + HALF;
        lft = longint'(b.src_left) * one - ax;
        top = longint'(b.src_top) * one - ay;
        rgt = longint'(b.src_right) * one - ax;
        bot = longint'(b.src_bottom) * one - ay;
        sx = longint'(b.scale_x);
        sy = longint'(b.scale_y);

        // Mirroring swaps the pair and negates it about the anchor.
        if (b.flip_mode[shw_pkg::FLIP_H_BIT]) begin
            tmp = -lft;
            lft = -rgt;
            rgt = tmp;
        end
        if (b.flip_mode[shw_pkg::FLIP_V_BIT]) begin
            tmp = -top;
            top = -bot;
            bot = tmp;
        end

        // A turn moves the edges around and then puts each pair back in
        // order. With no turn the box is left as given, even when inverted.
        if (b.quarter_turns != shw_pkg::TURN_NONE) begin
            l0 = lft;
            r0 = rgt;
            t0 = top;
            b0 = bot;
            case (b.quarter_turns)
                shw_pkg::TURN_QUARTER: begin
                    lft = b0;
                    rgt = t0;
                    bot = -r0;
                    top = -l0;
                end
                shw_pkg::TURN_HALF: begin
                    lft = -r0;
                    rgt = -l0;
                    bot = -t0;
                    top = -b0;
                end
                default: begin
                    lft = -t0;
                    rgt = -b0;
                    bot = l0;
                    top = r0;
                end
            endcase
            if (lft > rgt) begin
                tmp = lft;
                lft = rgt;
                rgt = tmp;
            end
            if (bot > top) begin
                tmp = bot;
                bot = top;
                top = tmp;
            end
        end

        // On odd turns the axes trade places, and so do the scales.
        if (b.quarter_turns == shw_pkg::TURN_QUARTER ||
                b.quarter_turns == shw_pkg::TURN_THREE) begin
            tmp = sx;
            sx = sy;
            sy = tmp;
        end

        ox = longint'(b.pos_x) * one - sx * HALF;
        oy = longint'(b.pos_y) * one + sy * HALF;
        w.left   = round_world_edge(ox + lft * sx);
        w.top    = round_world_edge(oy + top * sy);
        w.right  = round_world_edge(ox + rgt * sx);
        w.bottom = round_world_edge(oy + bot * sy);
        return w;
    endfunction

    function automatic box_item_t make_box(
        int left, int top, int right, int bottom,
        int pvx, int pvy, int px, int py,
        logic [shw_pkg::TURN_W-1:0] turns, int scx, int scy,
        logic [shw_pkg::FLIP_W-1:0] flips
    );
        box_item_t b;
        b.src_left      = EDGE_BITS'(left);
        b.src_top       = EDGE_BITS'(top);
        b.src_right     = EDGE_BITS'(right);
        b.src_bottom    = EDGE_BITS'(bottom);
        b.pivot_x       = shw_pkg::PIVOT_W'(pvx);
        b.pivot_y       = shw_pkg::PIVOT_W'(pvy);
        b.pos_x         = shw_pkg::POS_W'(px);
        b.pos_y         = shw_pkg::POS_W'(py);
        b.quarter_turns = turns;
        b.scale_x       = shw_pkg::SCALE_W'(scx);
        b.scale_y       = shw_pkg::SCALE_W'(scy);
        b.flip_mode     = flips;
        return b;
    endfunction

    // Fully random fields, with some items pulled toward the cases that
    // matter: small scales, a pivot sitting on the box, and edges at their
    // extremes.
    function automatic box_item_t random_box();
        box_item_t b;
        b.src_left      = EDGE_BITS'($urandom);
        b.src_top       = EDGE_BITS'($urandom);
        b.src_right     = EDGE_BITS'($urandom);
        b.src_bottom    = EDGE_BITS'($urandom);
        b.pivot_x       = shw_pkg::PIVOT_W'($urandom);
        b.pivot_y       = shw_pkg::PIVOT_W'($urandom);
        b.pos_x         = shw_pkg::POS_W'($urandom);
        b.pos_y         = shw_pkg::POS_W'($urandom);
        b.quarter_turns = shw_pkg::TURN_W'($urandom);
        b.scale_x       = shw_pkg::SCALE_W'($urandom);
        b.scale_y       = shw_pkg::SCALE_W'($urandom);
        b.flip_mode     = shw_pkg::FLIP_W'($urandom);
        case ($urandom_range(0, 4))
            0: begin
                b.scale_x = shw_pkg::SCALE_W'($urandom_range(0, 3));
                b.scale_y = shw_pkg::SCALE_W'($urandom_range(0, 3));
            end
            1: begin
                b.pivot_x = shw_pkg::PIVOT_W'({b.src_left, FRAC_BITS'($urandom)});
                b.pivot_y = shw_pkg::PIVOT_W'({b.src_bottom, FRAC_BITS'($urandom)});
                b.pos_x   = shw_pkg::POS_W'($urandom_range(0, 200) - 100);
                b.pos_y   = shw_pkg::POS_W'($urandom_range(0, 200) - 100);
            end
            2: begin
                b.src_left   = $urandom_range(0, 1) ? '0 : '1;
                b.src_right  = $urandom_range(0, 1) ? '0 : '1;
                b.src_top    = $urandom_range(0, 1) ? '0 : '1;
                b.src_bottom = $urandom_range(0, 1) ? '0 : '1;
            end
            default: begin
            end
        endcase
        return b;
    endfunction

    task automatic queue_box(box_item_t b);
        pending_boxes.push_back(b);
        queued_count++;
    endtask

    // Holds the stimulus back until every queued item is in and every
    // predicted world box has come out.
    task automatic wait_all_answered();
        while (accepted_count != queued_count || expected_boxes.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic run_phase(int idle_pct, int stall_pct, int n);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n; i++) begin
            queue_box(random_box());
        end
        wait_all_answered();
    endtask

    task automatic report_mismatch(string what, logic signed [shw_pkg::OUT_W-1:0] want,
                                   logic signed [shw_pkg::OUT_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("mismatch on %s: expected %0d, got %0d", what, want, got);
        end
    endtask

    // Driver. An accepted item is predicted right away. A new item is put on
    // the bus only when the previous one has gone or none was offered, so
    // valid and the payload hold steady while the block stalls.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_boxes.push_back(predict_world_box(cur_box));
                accepted_count++;
            end
            if (!s_valid || s_ready) begin
                if (pending_boxes.size() != 0 &&
                        $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_box = pending_boxes.pop_front();
                    s_valid         <= 1'b1;
                    s_src_left      <= cur_box.src_left;
                    s_src_top       <= cur_box.src_top;
                    s_src_right     <= cur_box.src_right;
                    s_src_bottom    <= cur_box.src_bottom;
                    s_pivot_x       <= cur_box.pivot_x;
                    s_pivot_y       <= cur_box.pivot_y;
                    s_pos_x         <= cur_box.pos_x;
                    s_pos_y         <= cur_box.pos_y;
                    s_quarter_turns <= cur_box.quarter_turns;
                    s_scale_x       <= cur_box.scale_x;
                    s_scale_y       <= cur_box.scale_y;
                    s_flip_mode     <= cur_box.flip_mode;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver. Normally ready follows the stall rate of the phase. Once the
    // hold-off is requested it stays low for a fixed run of cycles, which
    // fills both registers of the block and pushes back on the input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (rx_hold_req && !rx_hold_done) begin
            m_ready <= 1'b0;
            rx_hold_count <= rx_hold_count + 1;
            if (rx_hold_count == RX_HOLD_CYCLES - 1) begin
                rx_hold_done <= 1'b1;
            end
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Monitor. Each world box taken from the block is checked field by field
    // against the oldest prediction; a box with nothing predicted is an error.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_box.left   = m_world_left;
            got_box.top    = m_world_top;
            got_box.right  = m_world_right;
            got_box.bottom = m_world_bottom;
            if (expected_boxes.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("unexpected world box: left %0d top %0d right %0d bottom %0d",
                             got_box.left, got_box.top, got_box.right, got_box.bottom);
                end
            end else begin
                want_box = expected_boxes.pop_front();
                if (got_box.left !== want_box.left) begin
                    report_mismatch("world_left", want_box.left, got_box.left);
                end
                if (got_box.top !== want_box.top) begin
                    report_mismatch("world_top", want_box.top, got_box.top);
                end
                if (got_box.right !== want_box.right) begin
                    report_mismatch("world_right", want_box.right, got_box.right);
                end
                if (got_box.bottom !== want_box.bottom) begin
                    report_mismatch("world_bottom", want_box.bottom, got_box.bottom);
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_sprite_hitbox_world_bounds NOT OK");
            $finish;
        end
    end

    initial begin
        logic [shw_pkg::TURN_W-1:0] turn_codes[4];
        turn_codes = '{shw_pkg::TURN_NONE, shw_pkg::TURN_QUARTER, shw_pkg::TURN_HALF,
                       shw_pkg::TURN_THREE};

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, streamed back to back. First the field extremes:
        // all zero, all at maximum, the largest positive and negative boxes.
        queue_box(make_box(0, 0, 0, 0, 0, 0, 0, 0, shw_pkg::TURN_NONE, 0, 0, 2'b00));
        queue_box(make_box(4095, 4095, 4095, 4095, 65535, 65535, 32767, 32767,
                           shw_pkg::TURN_THREE, 255, 255, 2'b11));
        queue_box(make_box(4095, 4095, 4095, 4095, 0, 0, 32767, -32768,
                           shw_pkg::TURN_NONE, 255, 255, 2'b00));
        queue_box(make_box(0, 0, 0, 0, 65535, 65535, -32768, -32768,
                           shw_pkg::TURN_HALF, 255, 255, 2'b00));
        // Zero scale collapses the box onto the rounded origin; with an odd
        // turn the zero moves to the other axis.
        queue_box(make_box(100, 200, 300, 400, 1000, 2000, 50, -50,
                           shw_pkg::TURN_QUARTER, 0, 7, 2'b01));
        queue_box(make_box(100, 200, 300, 400, 1000, 2000, -7, 9,
                           shw_pkg::TURN_NONE, 0, 0, 2'b10));
        // An inverted box stays inverted without a turn but gets reordered
        // after one.
        queue_box(make_box(300, 400, 100, 200, 3000, 4000, 10, 20,
                           shw_pkg::TURN_NONE, 2, 3, 2'b00));
        queue_box(make_box(300, 400, 100, 200, 3000, 4000, 10, 20,
                           shw_pkg::TURN_QUARTER, 2, 3, 2'b00));
        // Every turn with every flip combination on one plain box.
        for (int t = 0; t < 4; t++) begin
            for (int f = 0; f < 4; f++) begin
                queue_box(make_box(10, 20, 50, 35, 16'h0180, 16'h0250, 100, -200,
                                   turn_codes[t], 3, 5, shw_pkg::FLIP_W'(f)));
            end
        end
        wait_all_answered();

        // Long hold-off on the result side while the sender keeps offering.
        // After that the sender pauses until the block has drained.
        rx_hold_req = 1'b1;
        for (int i = 0; i < HOLD_ITEMS; i++) begin
            queue_box(random_box());
        end
        while (!rx_hold_done) begin
            @(posedge aclk);
        end
        wait_all_answered();

        // Random phases across the idle patterns of both sides.
        run_phase(0, 0, PHASE_ITEMS);
        run_phase(66, 0, PHASE_ITEMS);
        run_phase(0, 66, PHASE_ITEMS);
        run_phase(34, 34, PHASE_ITEMS);

        // A few quiet cycles catch any world box the block sends unasked.
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_boxes.size() == 0) begin
            $display("tb_sprite_hitbox_world_bounds OK");
        end else begin
            $display("tb_sprite_hitbox_world_bounds NOT OK");
        end
        $finish;
    end

endmodule
